// File: rtl/o2avg_pkg.sv
// Package for the O2 sensor averaging core: widths, constants, register codes,
// sequencer states and the control structs passed between the core's modules.
// No dependencies.
package o2avg_pkg;

    localparam int WINDOW   = 60;
    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 15;
    localparam int MEAN_W   = 16;
    localparam int LEVEL_W  = 15;
    localparam int ZERO_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 14;

    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int NUM_W   = SUM_W + 5;
    localparam int PROD_W  = 2 * NUM_W;
    localparam logic [NUM_W-1:0] MEAN_RECIP = NUM_W'((64'd1 << NUM_W) / WINDOW);
    localparam logic [NUM_W-1:0] MEAN_HALF  = NUM_W'(WINDOW / 2);
    localparam logic [NUM_W-1:0] WINDOW_N   = NUM_W'(WINDOW);

    localparam int DIFF_W    = MEAN_W + 1;
    localparam int DG_W      = DIFF_W + GAIN_W + 1;
    localparam int F_W       = 19;
    localparam int P_W       = DG_W + F_W;
    localparam int X_W       = P_W + 1;
    localparam int REM_W     = 48;
    localparam int DIV_SHIFT = 21;
    localparam int Z_W       = REM_W - DIV_SHIFT;
    localparam int RECIP_W   = 16;
    localparam int QP_W      = Z_W + LEVEL_W;

    localparam longint LVL_DEN    = 64'd6553600000;
    localparam longint LVL_OFFSET = 64'd1 << (LEVEL_W - 1);
    localparam logic signed [F_W-1:0]   F_BASE   = F_W'(106000);
    localparam logic signed [X_W-1:0]   LVL_BIAS = X_W'(LVL_DEN / 2 + LVL_DEN * LVL_OFFSET);
    localparam logic signed [X_W-1:0]   LVL_TOP  = X_W'(LVL_DEN * 2 * LVL_OFFSET);
    localparam logic [Z_W-1:0]          LVL_ODD  = Z_W'(LVL_DEN >> DIV_SHIFT);
    localparam logic [RECIP_W-1:0]      LVL_RECIP =
        RECIP_W'((64'd1 << Z_W) / (LVL_DEN >> DIV_SHIFT));
    localparam logic [LEVEL_W-1:0]      LVL_OFS  = LEVEL_W'(LVL_OFFSET);
    localparam logic signed [LEVEL_W-1:0] LVL_MAX = LEVEL_W'(LVL_OFFSET - 1);
    localparam logic signed [LEVEL_W-1:0] LVL_MIN = LEVEL_W'(LVL_OFFSET);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_ZERO   = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(6600);
    localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(2000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MEAN_MUL,
        ST_MEAN_FIX,
        ST_MUL_GAIN,
        ST_MUL_TEMP,
        ST_DIV_LOAD,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic rd;
        logic upd;
        logic mul;
        logic fix;
    } win_ctrl_t;

    typedef struct packed {
        logic mul_gain;
        logic mul_temp;
        logic div_load;
        logic div_mul;
        logic div_fix;
    } lvl_ctrl_t;

endpackage

// File: rtl/o2avg_window.sv
// Sample ring memory, write pointer and running sum, plus the window mean in Q4
// through a reciprocal multiply with one correction step. Depends on o2avg_pkg.
module o2avg_window (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  o2avg_pkg::win_ctrl_t            ctrl,
    input  logic [o2avg_pkg::SAMPLE_W-1:0]  sample,
    output logic [o2avg_pkg::MEAN_W-1:0]    mean
);
    import o2avg_pkg::*;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] first_reg;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                primed_reg, primed_next;
    logic                wrapped_reg, wrapped_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [MEAN_W-1:0]   mean_reg;

    logic [SAMPLE_W-1:0] old_sample;
    logic                wp_last;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    q_est;
    logic [NUM_W-1:0]    rem;
    logic [NUM_W-1:0]    q_fix;

    assign old_sample = wrapped_reg ? rd_data_reg : first_reg;
    assign wp_last    = (wp_reg == PTR_W'(WINDOW - 1));
    assign num        = NUM_W'({sum_reg, 4'b0000}) + MEAN_HALF;
    assign q_est      = prod_reg[PROD_W-1:NUM_W];
    assign rem        = num - NUM_W'(q_est * WINDOW_N);
    assign q_fix      = (rem >= WINDOW_N) ? q_est + NUM_W'(1) : q_est;
    assign mean       = mean_reg;

    always_comb begin
        wp_next      = wp_reg;
        sum_next     = sum_reg;
        primed_next  = primed_reg;
        wrapped_next = wrapped_reg;
        if (ctrl.upd) begin
            if (!primed_reg) begin
                sum_next     = SUM_W'(SUM_W'(sample) * SUM_W'(WINDOW));
                wp_next      = '0;
                primed_next  = 1'b1;
                wrapped_next = 1'b0;
            end else begin
                sum_next = SUM_W'({1'b0, sum_reg} - (SUM_W + 1)'(old_sample)
                                  + (SUM_W + 1)'(sample));
                wp_next  = wp_last ? '0 : wp_reg + PTR_W'(1);
                if (wp_last) begin
                    wrapped_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            sum_reg     <= '0;
            primed_reg  <= 1'b0;
            wrapped_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            sum_reg     <= sum_next;
            primed_reg  <= primed_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rd_data_reg <= ring_mem[wp_reg];
        end
        if (ctrl.upd && primed_reg) begin
            ring_mem[wp_reg] <= sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd && !primed_reg) begin
            first_reg <= sample;
        end
        if (ctrl.mul) begin
            prod_reg <= num * MEAN_RECIP;
        end
        if (ctrl.fix) begin
            mean_reg <= MEAN_W'(q_fix);
        end
    end

endmodule

// File: rtl/o2avg_level.sv
// Scaling of the mean to hundredths of a percent O2 with temperature correction,
// a reciprocal-multiply rounding divide with saturation, and the alarm. Depends on o2avg_pkg.
module o2avg_level (
    input  logic                                 aclk,
    input  o2avg_pkg::lvl_ctrl_t                 ctrl,
    input  logic [o2avg_pkg::MEAN_W-1:0]         mean,
    input  logic [o2avg_pkg::ZERO_W-1:0]         zero_level_q4,
    input  logic [o2avg_pkg::GAIN_W-1:0]         percent_gain_q12,
    input  logic [o2avg_pkg::THR_W-1:0]          alarm_threshold,
    input  logic signed [o2avg_pkg::TEMP_W-1:0]  temperature,
    output logic signed [o2avg_pkg::LEVEL_W-1:0] level,
    output logic                                 alarm
);
    import o2avg_pkg::*;

    logic signed [DG_W-1:0]  dg_reg;
    logic signed [F_W-1:0]   f_reg;
    logic signed [P_W-1:0]   p_reg;
    logic [Z_W-1:0]          z_reg;
    logic [QP_W-1:0]         qp_reg;
    logic [LEVEL_W-1:0]      quo_reg;
    logic                    sat_hi_reg;
    logic                    sat_lo_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [F_W-1:0]    temp_ext;
    logic signed [X_W-1:0]    x_val;
    logic [LEVEL_W-1:0]       q_est;
    logic [Z_W-1:0]           q_rem;

    assign diff     = $signed({1'b0, mean}) - $signed(DIFF_W'(zero_level_q4));
    assign temp_ext = F_W'(temperature);
    assign x_val    = X_W'(p_reg) + LVL_BIAS;
    assign q_est    = qp_reg[QP_W-1:Z_W];
    assign q_rem    = z_reg - Z_W'(q_est) * LVL_ODD;

    always_comb begin
        if (sat_hi_reg) begin
            level = LVL_MAX;
        end else if (sat_lo_reg) begin
            level = LVL_MIN;
        end else begin
            level = $signed(quo_reg - LVL_OFS);
        end
        alarm = ($signed({level[LEVEL_W-1], level}) < $signed({2'b00, alarm_threshold}));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_gain) begin
            dg_reg <= DG_W'(diff) * $signed({2'b00, percent_gain_q12});
            f_reg  <= F_BASE - (temp_ext <<< 1) - temp_ext;
        end
        if (ctrl.mul_temp) begin
            p_reg <= P_W'(dg_reg) * P_W'(f_reg);
        end
        if (ctrl.div_load) begin
            sat_lo_reg <= x_val[X_W-1];
            sat_hi_reg <= !x_val[X_W-1] && (x_val >= LVL_TOP);
            z_reg      <= x_val[REM_W-1:DIV_SHIFT];
        end
        if (ctrl.div_mul) begin
            qp_reg <= QP_W'(z_reg) * QP_W'(LVL_RECIP);
        end
        if (ctrl.div_fix) begin
            quo_reg <= (q_rem >= LVL_ODD) ? q_est + LEVEL_W'(1) : q_est;
        end
    end

endmodule

// File: rtl/o2_sensor_average_and_alarm_core.sv
// O2 sensor averaging core: one sample and temperature per word in, window mean,
// corrected O2 level and low-oxygen alarm out; the 60-entry window lives in a
// synchronous RAM with registered read, and after the first word it averages over the
// last 60 samples. Each word runs through a fixed sequence before the next is taken:
// RAM read, sum update, mean multiply and correction, two scaling multiplies, then
// a three-step divide by the scale constant (shift, reciprocal multiply, correction)
// and the output load. A new word is taken while the previous result waits on
// m_ready; the one after it holds in the output state until that result drains.
// Registers via APB: 0x0 zero_level_q4, 0x4 percent_gain_q12, 0x8 alarm_threshold.
// The RAM needs no clearing pass: the first word after reset stands in for every entry.
module o2_sensor_average_and_alarm_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [o2avg_pkg::ADDR_W-1:0]         paddr,
    input  logic [o2avg_pkg::DATA_W-1:0]         pwdata,
    output logic [o2avg_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [o2avg_pkg::SAMPLE_W-1:0]       s_sample,
    input  logic signed [o2avg_pkg::TEMP_W-1:0]  s_temperature,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [o2avg_pkg::MEAN_W-1:0]         m_mean_q4,
    output logic signed [o2avg_pkg::LEVEL_W-1:0] m_oxygen_level,
    output logic                                 m_alarm
);
    import o2avg_pkg::*;

    state_t state_reg, state_next;

    logic [ZERO_W-1:0]         zero_level_q4_reg;
    logic [GAIN_W-1:0]         percent_gain_q12_reg;
    logic [THR_W-1:0]          alarm_threshold_reg;
    logic [SAMPLE_W-1:0]       sample_reg;
    logic signed [TEMP_W-1:0]  temperature_reg;
    logic                      m_valid_reg, m_valid_next;
    logic [MEAN_W-1:0]         m_mean_q4_reg;
    logic signed [LEVEL_W-1:0] m_oxygen_level_reg;
    logic                      m_alarm_reg;

    win_ctrl_t                 win_ctrl;
    lvl_ctrl_t                 lvl_ctrl;
    logic                      load_out;
    logic                      s_accept;
    logic                      cfg_write;
    logic [MEAN_W-1:0]         mean;
    logic signed [LEVEL_W-1:0] level;
    logic                      alarm;

    o2avg_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .sample  (sample_reg),
        .mean    (mean)
    );

    o2avg_level u_level (
        .aclk             (aclk),
        .ctrl             (lvl_ctrl),
        .mean             (mean),
        .zero_level_q4    (zero_level_q4_reg),
        .percent_gain_q12 (percent_gain_q12_reg),
        .alarm_threshold  (alarm_threshold_reg),
        .temperature      (temperature_reg),
        .level            (level),
        .alarm            (alarm)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        case (paddr[3:2])
            REG_ZERO:   prdata = DATA_W'(zero_level_q4_reg);
            REG_GAIN:   prdata = DATA_W'(percent_gain_q12_reg);
            REG_THRESH: prdata = DATA_W'(alarm_threshold_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_level_q4_reg    <= '0;
            percent_gain_q12_reg <= GAIN_RESET;
            alarm_threshold_reg  <= THRESH_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_ZERO:   zero_level_q4_reg    <= pwdata[ZERO_W-1:0];
                REG_GAIN:   percent_gain_q12_reg <= pwdata[GAIN_W-1:0];
                REG_THRESH: alarm_threshold_reg  <= pwdata[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_READ;
            ST_READ:     state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_MEAN_MUL;
            ST_MEAN_MUL: state_next = ST_MEAN_FIX;
            ST_MEAN_FIX: state_next = ST_MUL_GAIN;
            ST_MUL_GAIN: state_next = ST_MUL_TEMP;
            ST_MUL_TEMP: state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_MUL;
            ST_DIV_MUL:  state_next = ST_DIV_FIX;
            ST_DIV_FIX:  state_next = ST_OUT;
            ST_OUT:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        win_ctrl = '0;
        lvl_ctrl = '0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:     s_ready = 1'b1;
            ST_READ:     win_ctrl.rd = 1'b1;
            ST_UPDATE:   win_ctrl.upd = 1'b1;
            ST_MEAN_MUL: win_ctrl.mul = 1'b1;
            ST_MEAN_FIX: win_ctrl.fix = 1'b1;
            ST_MUL_GAIN: lvl_ctrl.mul_gain = 1'b1;
            ST_MUL_TEMP: lvl_ctrl.mul_temp = 1'b1;
            ST_DIV_LOAD: lvl_ctrl.div_load = 1'b1;
            ST_DIV_MUL:  lvl_ctrl.div_mul = 1'b1;
            ST_DIV_FIX:  lvl_ctrl.div_fix = 1'b1;
            ST_OUT:      load_out = !m_valid_reg || m_ready;
            default:     ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg      <= s_sample;
            temperature_reg <= s_temperature;
        end
        if (load_out) begin
            m_mean_q4_reg      <= mean;
            m_oxygen_level_reg <= level;
            m_alarm_reg        <= alarm;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mean_q4      = m_mean_q4_reg;
    assign m_oxygen_level = m_oxygen_level_reg;
    assign m_alarm        = m_alarm_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_READ))
        else $error("accepted word did not start the ring read");

    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    a_alarm_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_alarm_reg == ($signed({m_oxygen_level_reg[LEVEL_W-1],
            m_oxygen_level_reg}) < $signed({2'b00, alarm_threshold_reg}))))
        else $error("alarm disagrees with level and threshold");

endmodule

// File: sim/o2_reading_checker.sv
// Checker for the O2 sensor averaging core: tracks register writes on the APB port,
// predicts each result word from the accepted input words and compares in order.
// Depends on o2avg_pkg for widths and register codes.
module o2_reading_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [o2avg_pkg::ADDR_W-1:0]         paddr,
    input  logic [o2avg_pkg::DATA_W-1:0]         pwdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [o2avg_pkg::SAMPLE_W-1:0]       s_sample,
    input  logic signed [o2avg_pkg::TEMP_W-1:0]  s_temperature,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [o2avg_pkg::MEAN_W-1:0]         m_mean_q4,
    input  logic signed [o2avg_pkg::LEVEL_W-1:0] m_oxygen_level,
    input  logic                                 m_alarm,
    output logic [15:0]                          fail_count,
    output logic [15:0]                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import o2avg_pkg::*;

    localparam longint LEVEL_SCALE  = longint'(65536) * 100000;
    localparam int     REPORT_LIMIT = 100;

    typedef struct packed {
        logic [MEAN_W-1:0]         mean_q4;
        logic signed [LEVEL_W-1:0] oxygen_level;
        logic                      alarm;
    } o2_reading_t;

    logic [SAMPLE_W-1:0] window_mem [WINDOW];
    int unsigned         oldest_idx = 0;
    longint              window_total = 0;
    bit                  window_filled = 1'b0;

    logic [ZERO_W-1:0]   zero_level = '0;
    logic [GAIN_W-1:0]   gain = GAIN_RESET;
    logic [THR_W-1:0]    threshold = THRESH_RESET;

    o2_reading_t         expected_readings [$];
    int                  errors = 0;

    function automatic o2_reading_t predict_reading(input logic [SAMPLE_W-1:0] smp,
                                                    input logic signed [TEMP_W-1:0] tmp);
        longint      mean;
        longint      diff;
        longint      factor;
        longint      q;
        longint      level;
        o2_reading_t r;
        if (!window_filled) begin
            for (int i = 0; i < WINDOW; i++)
                window_mem[i] = smp;
            window_total = longint'(smp) * WINDOW;
            oldest_idx = 0;
            window_filled = 1'b1;
        end else begin
            window_total = window_total - longint'(window_mem[oldest_idx]) + longint'(smp);
            window_mem[oldest_idx] = smp;
            oldest_idx = (oldest_idx == WINDOW - 1) ? 0 : oldest_idx + 1;
        end
        mean = (window_total * 16 + WINDOW / 2) / WINDOW;
        diff = mean - longint'(zero_level);
        factor = 106000 - 3 * longint'(tmp);
        q = diff * longint'(gain) * factor + LEVEL_SCALE / 2;
        if (q >= 0)
            level = q / LEVEL_SCALE;
        else
            level = -((-q + LEVEL_SCALE - 1) / LEVEL_SCALE);
        if (level > 16383)
            level = 16383;
        if (level < -16384)
            level = -16384;
        r.mean_q4 = mean[MEAN_W-1:0];
        r.oxygen_level = level[LEVEL_W-1:0];
        r.alarm = (level < longint'(threshold));
        return r;
    endfunction

    always @(posedge aclk) begin
        o2_reading_t want;
        if (!aresetn) begin
            window_filled = 1'b0;
            oldest_idx = 0;
            window_total = 0;
            zero_level = '0;
            gain = GAIN_RESET;
            threshold = THRESH_RESET;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ZERO:   zero_level = pwdata[ZERO_W-1:0];
                    REG_GAIN:   gain = pwdata[GAIN_W-1:0];
                    REG_THRESH: threshold = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected word: mean_q4=%0d level=%0d alarm=%0d",
                                 $time, m_mean_q4, m_oxygen_level, m_alarm);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_mean_q4 !== want.mean_q4 || m_oxygen_level !== want.oxygen_level ||
                        m_alarm !== want.alarm) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected mean_q4=%0d level=%0d alarm=%0d, %s",
                                     $time, want.mean_q4, want.oxygen_level, want.alarm,
                                     $sformatf("got mean_q4=%0d level=%0d alarm=%0d",
                                               m_mean_q4, m_oxygen_level, m_alarm));
                    end
                end
            end
            if (s_valid && s_ready)
                expected_readings.push_back(predict_reading(s_sample, s_temperature));
        end
        fail_count <= 16'(errors);
        pending <= 16'(expected_readings.size());
    end

endmodule

// File: sim/testbench.sv
// Top of the O2 sensor averaging core test: clock, reset, APB register writes,
// bursty input words and a stalling result sink; o2_reading_checker does the checking.
// Depends on o2avg_pkg, o2_sensor_average_and_alarm_core and o2_reading_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import o2avg_pkg::*;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         LONG_HOLD      = 400;
    localparam int         IDLE_LIMIT     = 4000;
    localparam int         RANDOM_PHASES  = 8;
    localparam int         PHASE_WORDS    = 105;
    localparam int         DRAIN_CYCLES   = 24;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_W-1:0]           paddr = '0;
    logic [DATA_W-1:0]           pwdata = '0;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [SAMPLE_W-1:0]         s_sample = '0;
    logic signed [TEMP_W-1:0]    s_temperature = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [MEAN_W-1:0]           m_mean_q4;
    logic signed [LEVEL_W-1:0]   m_oxygen_level;
    logic                        m_alarm;

    logic [15:0]                 fail_count;
    logic [15:0]                 pending;
    bit                          hold_req = 1'b0;
    int                          idle_cycles = 0;
    logic [SAMPLE_W-1:0]         last_sample = '0;

    o2_sensor_average_and_alarm_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_temperature(s_temperature),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mean_q4(m_mean_q4), .m_oxygen_level(m_oxygen_level), .m_alarm(m_alarm)
    );

    o2_reading_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_temperature(s_temperature),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mean_q4(m_mean_q4), .m_oxygen_level(m_oxygen_level), .m_alarm(m_alarm),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int  seg_left;
        int  stall_pct;
        bit  hold_taken;
        seg_left = 0;
        stall_pct = 0;
        hold_taken = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_taken = 1'b1;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(200, 10);
                case ($urandom_range(2, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
            @(posedge aclk);
        end
    end

    task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic signed [TEMP_W-1:0] tmp);
        s_valid <= 1'b1;
        s_sample <= smp;
        s_temperature <= tmp;
        last_sample = smp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [ZERO_W-1:0] zero, input logic [GAIN_W-1:0] gain,
                                input logic [THR_W-1:0] thr);
        wait_drain();
        reg_write(REG_ZERO, {16'($urandom), zero});
        reg_write(REG_GAIN, {16'($urandom), gain});
        reg_write(REG_THRESH, {18'($urandom), thr});
        reg_write(REG_SPARE, $urandom);
    endtask

    task automatic random_word();
        logic [SAMPLE_W-1:0]      smp;
        logic signed [TEMP_W-1:0] tmp;
        int                       mode;
        mode = $urandom_range(9, 0);
        if (mode == 0)
            smp = '0;
        else if (mode == 1)
            smp = '1;
        else if (mode <= 5)
            smp = SAMPLE_W'(int'(last_sample) + $urandom_range(64, 0) - 32);
        else
            smp = SAMPLE_W'($urandom);
        if ($urandom_range(9, 0) < 7)
            tmp = TEMP_W'(int'($urandom_range(12500, 0)) - 4000);
        else
            tmp = TEMP_W'($urandom);
        send_word(smp, tmp);
    endtask

    task automatic run_traffic(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(30, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            for (int k = 0; k < burst && sent < count; k++) begin
                random_word();
                sent++;
            end
            if ($urandom_range(39, 0) == 0) begin
                wait_drain();
            end else if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin : stimulus
        logic [ZERO_W-1:0] zero;
        logic [GAIN_W-1:0] gain;
        logic [THR_W-1:0]  thr;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(12'hFFF, 15'sd2000);
        send_word(12'h000, 15'sd0);
        send_word(12'hFFF, -15'sd4000);
        send_word(12'h000, 15'sd8500);
        send_word(12'h555, 15'h4000);
        send_word(12'hAAA, 15'h3FFF);
        send_word(12'h001, -15'sd1);
        send_word(12'h800, 15'sd2000);

        apply_config(16'd65520, 16'hFFFF, 14'd10000);
        send_word(12'h000, 15'sd2000);
        send_word(12'hFFF, 15'sd8500);
        send_word(12'h064, 15'h4000);

        apply_config(16'd0, 16'hFFFF, 14'h3FFF);
        send_word(12'hFFF, 15'h4000);
        send_word(12'hFFF, 15'h3FFF);

        apply_config(16'd0, 16'd0, 14'd0);
        send_word(12'd1234, 15'sd0);

        apply_config(16'd0, 16'd1, 14'd1);
        send_word(12'hFFF, 15'sd2000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin
                    zero = ZERO_W'($urandom_range(20000, 0));
                    gain = GAIN_W'($urandom_range(12000, 2000));
                    thr = THR_W'($urandom_range(10000, 0));
                end
                1: begin
                    zero = ZERO_W'($urandom);
                    gain = GAIN_W'($urandom);
                    thr = THR_W'($urandom);
                end
                2: begin
                    zero = '0;
                    gain = GAIN_RESET;
                    thr = THRESH_RESET;
                end
                default: begin
                    zero = ZERO_W'($urandom_range(65520, 40000));
                    gain = '1;
                    thr = (p > 4) ? '1 : '0;
                end
            endcase
            apply_config(zero, gain, thr);
            if (p == 1)
                hold_req = 1'b1;
            run_traffic(PHASE_WORDS);
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: o2_sensor_average_and_alarm_core.f
rtl/o2avg_pkg.sv
rtl/o2avg_window.sv
rtl/o2avg_level.sv
rtl/o2_sensor_average_and_alarm_core.sv
sim/o2_reading_checker.sv
sim/testbench.sv
